// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AWN_ASSERT(NAME, PROP, MSG) \
  NAME: assert property (@(posedge clk_i) disable iff (!rst_ni) (PROP)) else $error(MSG);

// Condition that must never be true at a clock edge outside reset.
`define AWN_ASSERT_NEVER(NAME, COND, MSG) \
  NAME: assert property (@(posedge clk_i) disable iff (!rst_ni) !(COND)) else $error(MSG);

`endif

// ===== rtl/awn_pkg.sv =====
// ----------------------------------------------------------------------------
// awn_pkg
// Types, widths and register codes shared by the affine warp modules.
// ----------------------------------------------------------------------------
package awn_pkg;

  // Field widths of the transfers and registers.
  localparam int COORD_W    = 10;
  localparam int PIX_IO_W   = 8;
  localparam int COEF_W     = 16;
  localparam int OFFS_W     = 28;
  localparam int DIM_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  // Fixed-point datapath: Q.12 products and sums.
  localparam int FRAC_W     = 12;
  localparam int PROD_W     = COEF_W + COORD_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAG_W      = SUM_W - FRAC_W;
  localparam int ROUND_HALF = 2048;

  // Default sizes of the source store.
  localparam int DEF_SRC_MAX_WIDTH  = 128;
  localparam int DEF_SRC_MAX_HEIGHT = 128;
  localparam int DEF_PIXEL_BITS     = 8;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_D   = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_SRC_W    = 3'd6,
    REG_SRC_H    = 3'd7
  } awn_reg_e;

  // Action codes of an input item.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   row_index;
    logic [PIX_IO_W-1:0]  pixel_in;
  } awn_in_t;

  typedef struct packed {
    logic [PIX_IO_W-1:0]  pixel_out;
    logic                 in_range;
  } awn_out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic signed [OFFS_W-1:0] offset_x;
    logic signed [OFFS_W-1:0] offset_y;
    logic [DIM_W-1:0]         source_width;
    logic [DIM_W-1:0]         source_height;
  } awn_cfg_t;

  // Memory command from the coordinate pipeline to the store.
  typedef struct packed {
    logic req;   // slot holds an item
    logic wr;    // load (write) rather than request (read)
    logic hit;   // address inside the store / mapped point inside the source
  } awn_cmd_t;

  // Read response from the store.
  typedef struct packed {
    logic valid;
    logic hit;
  } awn_rsp_t;

endpackage

// ===== rtl/awn_map.sv =====
// ----------------------------------------------------------------------------
// awn_map
// Coordinate pipeline: products, sums, rounding and bounds check, ending in
// one memory command per item for the source store.
// ----------------------------------------------------------------------------
module awn_map #(
  parameter int SRC_MAX_WIDTH  = awn_pkg::DEF_SRC_MAX_WIDTH,
  parameter int SRC_MAX_HEIGHT = awn_pkg::DEF_SRC_MAX_HEIGHT,
  parameter int PIXEL_BITS     = awn_pkg::DEF_PIXEL_BITS,
  localparam int ADDR_W        = $clog2(SRC_MAX_WIDTH * SRC_MAX_HEIGHT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  awn_pkg::awn_in_t      item_i,
  input  awn_pkg::awn_cfg_t     cfg_i,
  output awn_pkg::awn_cmd_t     cmd_o,
  output logic [ADDR_W-1:0]     addr_o,
  output logic [PIXEL_BITS-1:0] wdata_o
);
  import awn_pkg::*;

  localparam int XW = $clog2(SRC_MAX_WIDTH);
  localparam int YW = $clog2(SRC_MAX_HEIGHT);
  localparam logic [COORD_W:0] MAXW_C = (COORD_W + 1)'(SRC_MAX_WIDTH);
  localparam logic [COORD_W:0] MAXH_C = (COORD_W + 1)'(SRC_MAX_HEIGHT);
  localparam logic [MAG_W-1:0] MAXW_M = MAG_W'(SRC_MAX_WIDTH);
  localparam logic [MAG_W-1:0] MAXH_M = MAG_W'(SRC_MAX_HEIGHT);

  // Valid bits of the stages.
  logic v1_q, v2_q, v3_q;

  // Item fields carried down the pipeline.
  logic                act1_q, act2_q, act3_q;
  logic [COORD_W-1:0]  col1_q, col2_q, col3_q;
  logic [COORD_W-1:0]  row1_q, row2_q, row3_q;
  logic [PIX_IO_W-1:0] pix1_q, pix2_q, pix3_q;

  // Products and sums.
  logic signed [PROD_W-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [SUM_W-1:0]  u_q, v_q;

  // Rounding and bounds check of the last stage.
  logic [SUM_W-1:0]  abs_u, abs_v, rnd_u, rnd_v;
  logic [MAG_W-1:0]  mag_u, mag_v;
  logic              in_x, in_y, load_ok;
  logic [ADDR_W-1:0] raddr, laddr;

  awn_cmd_t            cmd_d, cmd_q;
  logic [ADDR_W-1:0]   addr_d, addr_q;
  logic [PIXEL_BITS-1:0] wdata_d, wdata_q;

  // Valid pipeline, one item per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      cmd_q <= '0;
    end else begin
      v1_q  <= accept_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      cmd_q <= cmd_d;
    end
  end

  // Payload stages: capture, products, sums, memory command.
  always_ff @(posedge clk_i) begin
    act1_q  <= item_i.action;
    col1_q  <= item_i.column;
    row1_q  <= item_i.row_index;
    pix1_q  <= item_i.pixel_in;

    pa_q    <= PROD_W'(cfg_i.coef_a) * PROD_W'($signed({1'b0, col1_q}));
    pb_q    <= PROD_W'(cfg_i.coef_b) * PROD_W'($signed({1'b0, row1_q}));
    pc_q    <= PROD_W'(cfg_i.coef_c) * PROD_W'($signed({1'b0, col1_q}));
    pd_q    <= PROD_W'(cfg_i.coef_d) * PROD_W'($signed({1'b0, row1_q}));
    act2_q  <= act1_q;
    col2_q  <= col1_q;
    row2_q  <= row1_q;
    pix2_q  <= pix1_q;

    u_q     <= SUM_W'(pa_q) + SUM_W'(pb_q) + SUM_W'(cfg_i.offset_x);
    v_q     <= SUM_W'(pc_q) + SUM_W'(pd_q) + SUM_W'(cfg_i.offset_y);
    act3_q  <= act2_q;
    col3_q  <= col2_q;
    row3_q  <= row2_q;
    pix3_q  <= pix2_q;

    addr_q  <= addr_d;
    wdata_q <= wdata_d;
  end

  // Round half away from zero on the magnitude, then check the bounds.
  // A negative sum lands inside only when it rounds to zero.
  always_comb begin
    abs_u = u_q[SUM_W-1] ? SUM_W'(-u_q) : SUM_W'(u_q);
    abs_v = v_q[SUM_W-1] ? SUM_W'(-v_q) : SUM_W'(v_q);
    rnd_u = abs_u + SUM_W'(ROUND_HALF);
    rnd_v = abs_v + SUM_W'(ROUND_HALF);
    mag_u = rnd_u[SUM_W-1:FRAC_W];
    mag_v = rnd_v[SUM_W-1:FRAC_W];

    if (u_q[SUM_W-1]) begin
      in_x = (mag_u == '0) && (cfg_i.source_width != '0);
    end else begin
      in_x = (mag_u < MAG_W'(cfg_i.source_width)) && (mag_u < MAXW_M);
    end
    if (v_q[SUM_W-1]) begin
      in_y = (mag_v == '0) && (cfg_i.source_height != '0);
    end else begin
      in_y = (mag_v < MAG_W'(cfg_i.source_height)) && (mag_v < MAXH_M);
    end

    raddr = ADDR_W'(ADDR_W'(mag_v[YW-1:0]) * ADDR_W'(SRC_MAX_WIDTH))
          + ADDR_W'(mag_u[XW-1:0]);
  end

  // Load address; loads outside the store are dropped.
  always_comb begin
    load_ok = ({1'b0, col3_q} < MAXW_C) && ({1'b0, row3_q} < MAXH_C);
    laddr   = ADDR_W'(ADDR_W'(row3_q[YW-1:0]) * ADDR_W'(SRC_MAX_WIDTH))
            + ADDR_W'(col3_q[XW-1:0]);
  end

  // Memory command in item order, so loads and requests never pass each other.
  always_comb begin
    cmd_d.req = v3_q;
    cmd_d.wr  = (act3_q == ACT_LOAD);
    cmd_d.hit = (act3_q == ACT_REQUEST) ? (in_x && in_y) : load_ok;
    addr_d    = (act3_q == ACT_REQUEST) ? raddr : laddr;
    wdata_d   = PIXEL_BITS'(pix3_q);
  end

  assign cmd_o   = cmd_q;
  assign addr_o  = addr_q;
  assign wdata_o = wdata_q;

endmodule

// ===== rtl/awn_store.sv =====
// ----------------------------------------------------------------------------
// awn_store
// Source image store: one port, one write or one read per cycle, with the
// read data and its response flags registered.
// ----------------------------------------------------------------------------
module awn_store #(
  parameter int SRC_MAX_WIDTH  = awn_pkg::DEF_SRC_MAX_WIDTH,
  parameter int SRC_MAX_HEIGHT = awn_pkg::DEF_SRC_MAX_HEIGHT,
  parameter int PIXEL_BITS     = awn_pkg::DEF_PIXEL_BITS,
  localparam int ADDR_W        = $clog2(SRC_MAX_WIDTH * SRC_MAX_HEIGHT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  awn_pkg::awn_cmd_t     cmd_i,
  input  logic [ADDR_W-1:0]     addr_i,
  input  logic [PIXEL_BITS-1:0] wdata_i,
  output awn_pkg::awn_rsp_t     rsp_o,
  output logic [PIXEL_BITS-1:0] rdata_o
);
  import awn_pkg::*;

  localparam int DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rdata_q;
  awn_rsp_t              rsp_d, rsp_q;

  // Single port: a load writes, a request reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.req) begin
      if (cmd_i.wr) begin
        if (cmd_i.hit) begin
          mem[addr_i] <= wdata_i;
        end
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  // Response flags travel alongside the read.
  always_comb begin
    rsp_d.valid = cmd_i.req && !cmd_i.wr;
    rsp_d.hit   = cmd_i.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q <= '0;
    end else begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o   = rsp_q;
  assign rdata_o = rdata_q;

endmodule

// ===== rtl/affine_warp_nearest.sv =====
// ----------------------------------------------------------------------------
// affine_warp_nearest
// Affine image warp with nearest-neighbor sampling from an on-chip source.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy. A load
// writes one source pixel; a request maps its target point through the affine
// registers, rounds half away from zero and returns the source pixel, or zero
// with in_range low when the point falls outside the source. Each request
// gives its result on result_valid_o, in the order of the transfers, after
// three coordinate stages, the memory command register, the memory
// read and the result register. The result is shown for that one cycle only:
// the receiver must take it then. Loads and requests share the single port of
// the source memory in the same order as they were taken, so a request sees
// every load sent before it. The store is not cleared after reset; read only
// entries that have been loaded. Change the registers only when no request is
// in flight.
`include "assert_macros.svh"

module affine_warp_nearest #(
  parameter int SRC_MAX_WIDTH  = awn_pkg::DEF_SRC_MAX_WIDTH,
  parameter int SRC_MAX_HEIGHT = awn_pkg::DEF_SRC_MAX_HEIGHT,
  parameter int PIXEL_BITS     = awn_pkg::DEF_PIXEL_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  awn_pkg::awn_in_t               in_i,
  input  logic                           cfg_we_i,
  input  logic [awn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [awn_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                           result_valid_o,
  output awn_pkg::awn_out_t              out_o
);
  import awn_pkg::*;

  localparam int ADDR_W  = $clog2(SRC_MAX_WIDTH * SRC_MAX_HEIGHT);
  localparam int LATENCY = 6;

  awn_cfg_t              cfg_q;
  logic                  accept;
  logic                  req_xfer;
  awn_cmd_t              cmd;
  logic [ADDR_W-1:0]     addr;
  logic [PIXEL_BITS-1:0] wdata, rdata;
  awn_rsp_t              rsp;
  logic                  valid_q;
  awn_out_t              out_d, out_q;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign req_xfer = accept && (in_i.action == ACT_REQUEST);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_a        <= 16'sd4096;
      cfg_q.coef_b        <= '0;
      cfg_q.coef_c        <= '0;
      cfg_q.coef_d        <= 16'sd4096;
      cfg_q.offset_x      <= '0;
      cfg_q.offset_y      <= '0;
      cfg_q.source_width  <= 8'd128;
      cfg_q.source_height <= 8'd128;
    end else if (cfg_we_i) begin
      case (awn_reg_e'(cfg_idx_i))
        REG_COEF_A:   cfg_q.coef_a        <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_B:   cfg_q.coef_b        <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_C:   cfg_q.coef_c        <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_D:   cfg_q.coef_d        <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_OFFSET_X: cfg_q.offset_x      <= $signed(cfg_wdata_i[OFFS_W-1:0]);
        REG_OFFSET_Y: cfg_q.offset_y      <= $signed(cfg_wdata_i[OFFS_W-1:0]);
        REG_SRC_W:    cfg_q.source_width  <= cfg_wdata_i[DIM_W-1:0];
        REG_SRC_H:    cfg_q.source_height <= cfg_wdata_i[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  awn_map #(
    .SRC_MAX_WIDTH (SRC_MAX_WIDTH),
    .SRC_MAX_HEIGHT(SRC_MAX_HEIGHT),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_i),
    .cfg_i   (cfg_q),
    .cmd_o   (cmd),
    .addr_o  (addr),
    .wdata_o (wdata)
  );

  awn_store #(
    .SRC_MAX_WIDTH (SRC_MAX_WIDTH),
    .SRC_MAX_HEIGHT(SRC_MAX_HEIGHT),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .addr_i (addr),
    .wdata_i(wdata),
    .rsp_o  (rsp),
    .rdata_o(rdata)
  );

  // Result register: zero pixel when the point misses the source.
  always_comb begin
    out_d.pixel_out = rsp.hit ? PIX_IO_W'(rdata) : '0;
    out_d.in_range  = rsp.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = valid_q;
  assign out_o          = out_q;

  // Every request transfer yields a result a fixed time later.
  `AWN_ASSERT(a_req_result, req_xfer |-> ##LATENCY result_valid_o, "request lost")
  // No result appears without a request transfer.
  `AWN_ASSERT(a_no_extra, !req_xfer |-> ##LATENCY !result_valid_o, "result invented")
  // A miss always returns a zero pixel.
  `AWN_ASSERT_NEVER(a_miss_zero, result_valid_o && !out_o.in_range && out_o.pixel_out != '0, "miss with pixel")

endmodule

// ===== sim/affine_warp_nearest_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_warp_nearest_test
// Self-checking bench for the affine warp. It loads source pixels, steps the
// warp registers through a range of settings and checks every sampled pixel
// against a prediction that it keeps of the source store and the registers.
// ----------------------------------------------------------------------------
module affine_warp_nearest_test;
  import awn_pkg::*;

  localparam int STORE_W       = DEF_SRC_MAX_WIDTH;
  localparam int STORE_H       = DEF_SRC_MAX_HEIGHT;
  localparam int LATENCY       = 6;
  localparam int SETTLE_CYCLES = LATENCY + 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 100;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 115;
  localparam int Q12_ONE       = 4096;
  localparam int COEF_MAX      = 32767;
  localparam int COEF_MIN      = -32768;
  localparam int OFFS_MAX      = (1 << 27) - 1;
  localparam int OFFS_MIN      = -(1 << 27);

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  awn_in_t               in_item;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  result_valid_o;
  awn_out_t              out_o;

  // Shadow of the warp registers and of the source store.
  awn_cfg_t            warp_cfg;
  logic [PIX_IO_W-1:0] source_shadow [STORE_W*STORE_H];
  bit                  loaded [STORE_W*STORE_H];
  awn_out_t            expected_pixels [$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int sent_count  = 0;

  affine_warp_nearest u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_item),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .out_o          (out_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: a run that hangs or loses results ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    error_count++;
  endtask

  // Round a Q.12 value to an integer, half away from zero.
  function automatic longint round_q12(input longint q);
    if (q >= 0) begin
      return (q + ROUND_HALF) >>> FRAC_W;
    end
    return -((-q + ROUND_HALF) >>> FRAC_W);
  endfunction

  // Map a target point into the source; returns whether it lands inside.
  function automatic bit map_point(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                                   output int unsigned addr);
    longint x, y, u, v, sx, sy, w, h;
    x = longint'(col);
    y = longint'(row);
    u = longint'($signed(warp_cfg.coef_a)) * x + longint'($signed(warp_cfg.coef_b)) * y
        + longint'($signed(warp_cfg.offset_x));
    v = longint'($signed(warp_cfg.coef_c)) * x + longint'($signed(warp_cfg.coef_d)) * y
        + longint'($signed(warp_cfg.offset_y));
    sx = round_q12(u);
    sy = round_q12(v);
    // Sizes above the store saturate to the store.
    w = longint'(warp_cfg.source_width);
    h = longint'(warp_cfg.source_height);
    if (w > STORE_W) w = STORE_W;
    if (h > STORE_H) h = STORE_H;
    addr = 0;
    if (sx >= 0 && sx < w && sy >= 0 && sy < h) begin
      addr = int'(sy) * STORE_W + int'(sx);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Compare each strobed result with the oldest expected sample.
  always @(posedge clk_i) begin
    awn_out_t want;
    if (rst_ni === 1'b1 && result_valid_o !== 1'b0) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_pixels.pop_front();
        if (out_o.pixel_out !== want.pixel_out) begin
          report_mismatch($sformatf("pixel_out %0h, expected %0h", out_o.pixel_out,
                                    want.pixel_out));
        end
        if (out_o.in_range !== want.in_range) begin
          report_mismatch($sformatf("in_range %0b, expected %0b", out_o.in_range,
                                    want.in_range));
        end
      end
    end
  end

  // Present one item, hold it until the transfer, then update the shadow.
  task automatic send_item(input awn_in_t item);
    int unsigned addr;
    awn_out_t    want;
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sent_count++;
    if (item.action == ACT_LOAD) begin
      // Loads outside the store are dropped.
      if (item.column < STORE_W && item.row_index < STORE_H) begin
        addr = item.row_index * STORE_W + item.column;
        source_shadow[addr] = item.pixel_in;
        loaded[addr] = 1'b1;
      end
    end else begin
      if (map_point(item.column, item.row_index, addr)) begin
        want = awn_out_t'{pixel_out: source_shadow[addr], in_range: 1'b1};
      end else begin
        want = awn_out_t'{pixel_out: '0, in_range: 1'b0};
      end
      expected_pixels.push_back(want);
    end
  endtask

  task automatic send_load(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                           input logic [PIX_IO_W-1:0] pix);
    send_item(awn_in_t'{action: ACT_LOAD, column: col, row_index: row, pixel_in: pix});
  endtask

  // A request that would sample an unloaded pixel gets that pixel loaded first.
  task automatic send_request(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int unsigned addr;
    if (map_point(col, row, addr) && !loaded[addr]) begin
      send_load(COORD_W'(addr % STORE_W), COORD_W'(addr / STORE_W), PIX_IO_W'($urandom));
    end
    send_item(awn_in_t'{action: ACT_REQUEST, column: col, row_index: row,
                        pixel_in: PIX_IO_W'($urandom)});
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every outstanding request has answered.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end
    burst_left--;
  endtask

  // Keep the low bits of a register value and fill the rest with noise.
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input int w);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
    return (CFG_DATA_W'($urandom) & ~mask) | (v & mask);
  endfunction

  task automatic write_reg(input awn_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_COEF_A:   warp_cfg.coef_a = data[COEF_W-1:0];
      REG_COEF_B:   warp_cfg.coef_b = data[COEF_W-1:0];
      REG_COEF_C:   warp_cfg.coef_c = data[COEF_W-1:0];
      REG_COEF_D:   warp_cfg.coef_d = data[COEF_W-1:0];
      REG_OFFSET_X: warp_cfg.offset_x = data[OFFS_W-1:0];
      REG_OFFSET_Y: warp_cfg.offset_y = data[OFFS_W-1:0];
      REG_SRC_W:    warp_cfg.source_width = data[DIM_W-1:0];
      REG_SRC_H:    warp_cfg.source_height = data[DIM_W-1:0];
      default: ;
    endcase
  endtask

  // Let the pipeline empty, then write the whole register set.
  task automatic set_warp(input int a, input int b, input int c, input int d,
                          input int ox, input int oy, input int w, input int h);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_COEF_A, with_junk(CFG_DATA_W'(a), COEF_W));
    write_reg(REG_COEF_B, with_junk(CFG_DATA_W'(b), COEF_W));
    write_reg(REG_COEF_C, with_junk(CFG_DATA_W'(c), COEF_W));
    write_reg(REG_COEF_D, with_junk(CFG_DATA_W'(d), COEF_W));
    write_reg(REG_OFFSET_X, with_junk(CFG_DATA_W'(ox), OFFS_W));
    write_reg(REG_OFFSET_Y, with_junk(CFG_DATA_W'(oy), OFFS_W));
    write_reg(REG_SRC_W, with_junk(CFG_DATA_W'(w), DIM_W));
    write_reg(REG_SRC_H, with_junk(CFG_DATA_W'(h), DIM_W));
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rand_span(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic int pick_coef();
    case ($urandom_range(0, 3))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return 0;
      default: return int'($signed(COEF_W'($urandom)));
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 2))
      0:       return OFFS_MIN;
      1:       return OFFS_MAX;
      default: return int'($signed(OFFS_W'($urandom)));
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1;
      2:       return STORE_W;
      3:       return (1 << DIM_W) - 1;
      default: return int'($urandom_range(0, (1 << DIM_W) - 1));
    endcase
  endfunction

  // Kind 0 is close to identity, kind 1 a general map, kind 2 the extremes.
  task automatic pick_warp(input int kind);
    int a, b, c, d;
    int ox, oy;
    int w, h;
    case (kind)
      0: begin
        a  = Q12_ONE + rand_span(1024);
        b  = rand_span(1024);
        c  = rand_span(1024);
        d  = Q12_ONE + rand_span(1024);
        ox = rand_span(32 * Q12_ONE);
        oy = rand_span(32 * Q12_ONE);
        w  = ($urandom_range(0, 1) != 0) ? STORE_W : int'($urandom_range(1, STORE_W));
        h  = ($urandom_range(0, 1) != 0) ? STORE_H : int'($urandom_range(1, STORE_H));
      end
      1: begin
        a  = rand_span(8192);
        b  = rand_span(8192);
        c  = rand_span(8192);
        d  = rand_span(8192);
        ox = 64 * Q12_ONE + rand_span(64 * Q12_ONE);
        oy = 64 * Q12_ONE + rand_span(64 * Q12_ONE);
        w  = int'($urandom_range(1, STORE_W));
        h  = int'($urandom_range(1, STORE_H));
      end
      default: begin
        a  = pick_coef();
        b  = pick_coef();
        c  = pick_coef();
        d  = pick_coef();
        ox = pick_offset();
        oy = pick_offset();
        w  = pick_dim();
        h  = pick_dim();
      end
    endcase
    set_warp(a, b, c, d, ox, oy, w, h);
  endtask

  // Corners of the store, loads outside it, and a request right behind its load.
  task automatic test_store_edges();
    send_load(0, 0, 8'hFF);
    send_load(127, 127, 8'h00);
    send_load(127, 0, 8'hA5);
    send_load(0, 6, 8'h3C);
    // Both of these lie outside the store and must not disturb it.
    send_load(128, 5, 8'hC3);
    send_load(1023, 1023, 8'h99);
    send_request(0, 0);
    send_request(127, 127);
    send_request(127, 0);
    send_request(0, 6);
    send_request(128, 0);
    send_request(1023, 1023);
    send_request(64, 33);
  endtask

  // Exact halves round away from zero, values just short of a half do not.
  task automatic test_rounding();
    set_warp(Q12_ONE, 0, 0, Q12_ONE, -2048, 2047, STORE_W, STORE_H);
    send_request(0, 0);
    send_request(1, 5);
    set_warp(Q12_ONE, 0, 0, Q12_ONE, -2047, 2048, STORE_W, STORE_H);
    send_request(0, 0);
    // Mirrored columns.
    set_warp(-Q12_ONE, 0, 0, Q12_ONE, 127 * Q12_ONE, 0, STORE_W, STORE_H);
    send_request(0, 3);
    send_request(128, 3);
  endtask

  // Zero sizes, sizes above the store, and a one-pixel source.
  task automatic test_source_size();
    set_warp(Q12_ONE, 0, 0, Q12_ONE, 0, 0, 0, STORE_H);
    send_request(0, 0);
    set_warp(Q12_ONE, 0, 0, Q12_ONE, 0, 0, STORE_W, 0);
    send_request(0, 0);
    set_warp(Q12_ONE, 0, 0, Q12_ONE, 0, 0, 255, 200);
    send_request(127, 127);
    send_request(128, 5);
    set_warp(Q12_ONE, 0, 0, Q12_ONE, 0, 0, 1, 1);
    send_request(0, 0);
    send_request(1, 0);
  endtask

  task automatic test_coef_extremes();
    set_warp(0, COEF_MAX, COEF_MIN, 0, 0, 127 * Q12_ONE, STORE_W, STORE_H);
    send_request(3, 2);
    set_warp(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, OFFS_MAX, OFFS_MIN, 255, 255);
    send_request(1023, 1023);
  endtask

  // Random phases: each picks a warp, then streams mixed loads and requests
  // in bursts, with one full drain halfway through.
  task automatic test_random_warps();
    int                 kind;
    int                 pick;
    int                 phase_start;
    bit                 drained;
    logic [COORD_W-1:0] col, row;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = (p % 4 == 3 || p == RANDOM_PHASES - 1) ? 2 : p % 2;
      pick_warp(kind);
      burst_left  = 0;
      phase_start = sent_count;
      drained     = 1'b0;
      // Loads put ahead of requests count toward the phase as well.
      while (sent_count - phase_start < PHASE_ITEMS) begin
        if (!drained && sent_count - phase_start >= PHASE_ITEMS / 2) begin
          drain_results();
          drained = 1'b1;
        end
        pace_sender();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          if (pick < 17) begin
            col = COORD_W'($urandom_range(0, STORE_W - 1));
            row = COORD_W'($urandom_range(0, STORE_H - 1));
          end else begin
            col = COORD_W'($urandom);
            row = COORD_W'($urandom);
          end
          send_load(col, row, PIX_IO_W'($urandom));
        end else begin
          if (kind != 2 && pick < 85) begin
            col = COORD_W'($urandom_range(0, STORE_W + 7));
            row = COORD_W'($urandom_range(0, STORE_H + 7));
          end else begin
            col = COORD_W'($urandom);
            row = COORD_W'($urandom);
          end
          send_request(col, row);
        end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_COEF_A;
    cfg_wdata_i = '0;
    warp_cfg    = '{coef_a: COEF_W'(Q12_ONE), coef_b: '0, coef_c: '0,
                    coef_d: COEF_W'(Q12_ONE), offset_x: '0, offset_y: '0,
                    source_width: DIM_W'(STORE_W), source_height: DIM_W'(STORE_H)};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_store_edges();
    test_rounding();
    test_source_size();
    test_coef_extremes();
    test_random_warps();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
